### src/stepdrv_pkg.sv
// ----------------------------------------------------------------------------
// stepdrv_pkg
// Shared types and constants for the stepper command half-step driver.
// ----------------------------------------------------------------------------
package stepdrv_pkg;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [1:0] SIGN_NONE = 2'd0;
  localparam logic [1:0] SIGN_CW   = 2'd1;
  localparam logic [1:0] SIGN_CCW  = 2'd2;

  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_START    = 2'd1;
  localparam logic [1:0] ST_NO_X     = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [7:0] HOLD_RESET = 8'd4;
  localparam logic [2:0] TOKEN_POS_MAX = 3'd5;

  typedef struct packed {
    logic       go;
    logic       dir;
    logic [9:0] cycles;
  } start_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] coils;
  } seq_out_t;

  function automatic logic [3:0] seq_coils(input logic dir, input logic [2:0] idx);
    logic [3:0] c;
    if (dir) begin
      unique case (idx)
        3'd0: c = 4'd4;
        3'd1: c = 4'd6;
        3'd2: c = 4'd2;
        3'd3: c = 4'd10;
        3'd4: c = 4'd8;
        3'd5: c = 4'd9;
        3'd6: c = 4'd1;
        default: c = 4'd5;
      endcase
    end else begin
      unique case (idx)
        3'd0: c = 4'd1;
        3'd1: c = 4'd9;
        3'd2: c = 4'd8;
        3'd3: c = 4'd10;
        3'd4: c = 4'd2;
        3'd5: c = 4'd6;
        3'd6: c = 4'd4;
        default: c = 4'd5;
      endcase
    end
    return c;
  endfunction

endpackage

### src/stepdrv_parser.sv
// ----------------------------------------------------------------------------
// stepdrv_parser
// Command line collector: tracks tokens, latches the last X token and
// issues a motion start or a status on the line terminator.
// ----------------------------------------------------------------------------
module stepdrv_parser #(
  parameter int LINE_BYTES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_ev,
  input  logic [7:0]           rx_byte,
  output stepdrv_pkg::start_t  start,
  output logic [1:0]           line_status
);

  localparam int LenW = $clog2(LINE_BYTES + 2);
  localparam logic [LenW-1:0] LenMax   = LenW'(LINE_BYTES + 1);
  localparam logic [LenW-1:0] LenLimit = LenW'(LINE_BYTES);

  logic [LenW-1:0] line_length, line_length_next, len_inc;
  logic [2:0]      token_position, token_position_next;
  logic            token_is_x, token_is_x_next;
  logic [1:0]      pending_sign, pending_sign_next;
  logic [11:0]     pending_digits, pending_digits_next;
  logic            pending_valid, pending_valid_next;
  logic            is_digit;

  assign len_inc  = (line_length < LenMax) ? line_length + 1'b1 : line_length;
  assign is_digit = (rx_byte >= stepdrv_pkg::CH_0) && (rx_byte <= stepdrv_pkg::CH_9);

  always_comb begin
    line_length_next    = line_length;
    token_position_next = token_position;
    token_is_x_next     = token_is_x;
    pending_sign_next   = pending_sign;
    pending_digits_next = pending_digits;
    pending_valid_next  = pending_valid;
    start               = '0;
    line_status         = stepdrv_pkg::ST_NONE;
    if (byte_ev) begin
      line_length_next = len_inc;
      if (rx_byte == stepdrv_pkg::CH_HASH) begin
        if (len_inc > LenLimit) begin
          line_status = stepdrv_pkg::ST_OVERFLOW;
        end else if (pending_valid && pending_sign != stepdrv_pkg::SIGN_NONE) begin
          line_status  = stepdrv_pkg::ST_START;
          start.go     = 1'b1;
          start.dir    = (pending_sign == stepdrv_pkg::SIGN_CCW);
          start.cycles = 10'(pending_digits[11:8]) * 10'd100
                       + 10'(pending_digits[7:4]) * 10'd10
                       + 10'(pending_digits[3:0]) + 10'd1;
        end else begin
          line_status = stepdrv_pkg::ST_NO_X;
        end
        line_length_next    = '0;
        token_position_next = '0;
        token_is_x_next     = 1'b0;
        pending_sign_next   = stepdrv_pkg::SIGN_NONE;
        pending_digits_next = '0;
        pending_valid_next  = 1'b0;
      end else if (rx_byte == stepdrv_pkg::CH_SPACE) begin
        token_position_next = '0;
        token_is_x_next     = 1'b0;
      end else begin
        if (token_position == 3'd0) begin
          token_is_x_next = (rx_byte == stepdrv_pkg::CH_X);
          if (rx_byte == stepdrv_pkg::CH_X) begin
            pending_sign_next   = stepdrv_pkg::SIGN_NONE;
            pending_digits_next = '0;
            pending_valid_next  = 1'b0;
          end
        end else if (token_is_x && token_position == 3'd1) begin
          if (rx_byte == stepdrv_pkg::CH_0) begin
            pending_sign_next = stepdrv_pkg::SIGN_CW;
          end else if (rx_byte == stepdrv_pkg::CH_MINUS) begin
            pending_sign_next = stepdrv_pkg::SIGN_CCW;
          end else begin
            pending_sign_next = stepdrv_pkg::SIGN_NONE;
          end
        end else if (token_is_x && token_position <= 3'd4) begin
          if (is_digit && pending_sign != stepdrv_pkg::SIGN_NONE) begin
            pending_digits_next = {pending_digits[7:0], rx_byte[3:0]};
            if (token_position == 3'd4) begin
              pending_valid_next = 1'b1;
            end
          end else begin
            pending_sign_next = stepdrv_pkg::SIGN_NONE;
          end
        end
        if (token_position < stepdrv_pkg::TOKEN_POS_MAX) begin
          token_position_next = token_position + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length    <= '0;
      token_position <= '0;
      token_is_x     <= 1'b0;
      pending_sign   <= stepdrv_pkg::SIGN_NONE;
      pending_digits <= '0;
      pending_valid  <= 1'b0;
    end else begin
      line_length    <= line_length_next;
      token_position <= token_position_next;
      token_is_x     <= token_is_x_next;
      pending_sign   <= pending_sign_next;
      pending_digits <= pending_digits_next;
      pending_valid  <= pending_valid_next;
    end
  end

endmodule

### src/stepdrv_seq.sv
// ----------------------------------------------------------------------------
// stepdrv_seq
// Half-step sequencer: phase hold counter, phase index and cycle count.
// ----------------------------------------------------------------------------
module stepdrv_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick_ev,
  input  stepdrv_pkg::start_t   start,
  input  logic [7:0]            hold_ticks,
  output logic                  moving,
  output stepdrv_pkg::seq_out_t seq_next
);

  logic       moving_next;
  logic       move_direction, move_direction_next;
  logic [9:0] cycles_left, cycles_left_next, cycles_dec;
  logic [2:0] phase_index, phase_index_next;
  logic [7:0] hold_counter, hold_counter_next, hold_inc;

  assign hold_inc   = hold_counter + 8'd1;
  assign cycles_dec = (cycles_left != '0) ? cycles_left - 10'd1 : cycles_left;

  always_comb begin
    moving_next         = moving;
    move_direction_next = move_direction;
    cycles_left_next    = cycles_left;
    phase_index_next    = phase_index;
    hold_counter_next   = hold_counter;
    priority if (start.go) begin
      moving_next         = 1'b1;
      move_direction_next = start.dir;
      cycles_left_next    = start.cycles;
      phase_index_next    = '0;
      hold_counter_next   = '0;
    end else if (tick_ev && moving) begin
      if (hold_inc >= hold_ticks) begin
        hold_counter_next = '0;
        if (phase_index == 3'd7) begin
          phase_index_next = '0;
          cycles_left_next = cycles_dec;
          if (cycles_dec == '0) begin
            moving_next = 1'b0;
          end
        end else begin
          phase_index_next = phase_index + 3'd1;
        end
      end else begin
        hold_counter_next = hold_inc;
      end
    end
  end

  assign seq_next.busy  = moving_next;
  assign seq_next.coils = moving_next ?
                          stepdrv_pkg::seq_coils(move_direction_next, phase_index_next) : 4'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      moving         <= 1'b0;
      move_direction <= 1'b0;
      cycles_left    <= '0;
      phase_index    <= '0;
      hold_counter   <= '0;
    end else begin
      moving         <= moving_next;
      move_direction <= move_direction_next;
      cycles_left    <= cycles_left_next;
      phase_index    <= phase_index_next;
      hold_counter   <= hold_counter_next;
    end
  end

endmodule

### src/stepper_command_half_step_driver.sv
// ----------------------------------------------------------------------------
// stepper_command_half_step_driver
// Command line interpreter driving a four-coil stepper in half steps.
// ----------------------------------------------------------------------------
// One beat in, one beat out. Each input beat (a received byte, or a 1 ms
// tick when tuser is set) is taken, and its result beat appears in the
// output register on the next cycle, so one beat per cycle is sustained
// while the master takes beats. The output register sets the pace: tready
// drops only while a result is held there by master-side back-pressure.
// The result carries the coil drive and busy flag after the beat, plus a
// line status that is nonzero only on the beat that accepts '#'.
// Bytes received in motion are dropped; cfg_we/cfg_wdata set hold_ticks.
module stepper_command_half_step_driver #(
  parameter int LINE_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic       s_axis_tuser,   // [0] action
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [3:0] coils, [4] busy_res, [6:5] line_status
);

  logic                  phase_hold_ticks;
  logic [7:0]            hold_ticks;
  logic                  accept;
  logic                  moving;
  logic                  byte_ev, tick_ev;
  logic [1:0]            line_status;
  stepdrv_pkg::start_t   start;
  stepdrv_pkg::seq_out_t seq_next;

  assign phase_hold_ticks = cfg_we;
  assign s_axis_tready    = !m_axis_tvalid || m_axis_tready;
  assign accept           = s_axis_tvalid && s_axis_tready;
  assign byte_ev          = accept && !s_axis_tuser && !moving;
  assign tick_ev          = accept && s_axis_tuser;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= stepdrv_pkg::HOLD_RESET;
    end else if (phase_hold_ticks) begin
      hold_ticks <= cfg_wdata;
    end
  end

  stepdrv_parser #(
    .LINE_BYTES (LINE_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .byte_ev     (byte_ev),
    .rx_byte     (s_axis_tdata),
    .start       (start),
    .line_status (line_status)
  );

  stepdrv_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .tick_ev    (tick_ev),
    .start      (start),
    .hold_ticks (hold_ticks),
    .moving     (moving),
    .seq_next   (seq_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {1'b0, line_status, seq_next.busy, seq_next.coils};
    end
  end

endmodule

### src/stepdrv_checker.sv
// ----------------------------------------------------------------------------
// stepdrv_checker
// Port-level checks for the stepper command half-step driver.
// ----------------------------------------------------------------------------
module stepdrv_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_coils_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[3:0] == 4'd0)
    else $error("coils driven while not busy");

  a_status_on_hash: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready &&
    (s_axis_tuser || s_axis_tdata != stepdrv_pkg::CH_HASH)
    |=> m_axis_tdata[6:5] == stepdrv_pkg::ST_NONE)
    else $error("line status set without a terminator");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[6:5] == stepdrv_pkg::ST_START |-> m_axis_tdata[4])
    else $error("motion started but not busy");

endmodule

bind stepper_command_half_step_driver stepdrv_checker u_stepdrv_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### verif/stepper_command_half_step_driver_chk.sv
// ----------------------------------------------------------------------------
// stepper_command_half_step_driver_chk
// Watches both streams of the half-step driver, predicts each result beat
// from the accepted input beats and the hold setting, and compares them
// field by field in order.
// ----------------------------------------------------------------------------
module stepper_command_half_step_driver_chk #(
  parameter int LINE_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tuser,
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,
  output int         fails,
  output int         waiting,
  output logic       motor_busy,
  output int         beats_checked,
  output int         starts,
  output int         rejects,
  output int         overflows
);
  timeunit 1ns;
  timeprecision 1ps;

  // coil codes per phase, phase 0 in the lowest nibble
  localparam logic [31:0] CW_COILS  = {4'd5, 4'd4, 4'd6, 4'd2, 4'd10, 4'd8, 4'd9, 4'd1};
  localparam logic [31:0] CCW_COILS = {4'd5, 4'd1, 4'd9, 4'd8, 4'd10, 4'd2, 4'd6, 4'd4};

  typedef struct packed {
    logic [1:0] status;
    logic       busy;
    logic [3:0] coils;
  } drive_t;

  logic [7:0]  hold_ticks;
  int          line_len;
  int          tok_pos;
  logic        tok_x;
  logic [1:0]  pend_sign;
  logic [11:0] pend_digits;
  logic        pend_valid;
  logic        dir_ccw;
  logic [9:0]  cycles_left;
  logic [2:0]  phase;
  logic [7:0]  hold_cnt;
  logic        moving;

  drive_t drive_due[$];
  drive_t due, got, fresh;
  int errs = 0;
  int n_beats = 0;
  int n_start = 0;
  int n_rej = 0;
  int n_ovf = 0;

  task automatic clear_line();
    line_len    = 0;
    tok_pos     = 0;
    tok_x       = 1'b0;
    pend_sign   = stepdrv_pkg::SIGN_NONE;
    pend_digits = '0;
    pend_valid  = 1'b0;
  endtask

  task automatic predict_drive(input logic act, input logic [7:0] rx, output drive_t d);
    int n;
    d.status = stepdrv_pkg::ST_NONE;
    if (act) begin
      if (moving) begin
        hold_cnt = hold_cnt + 8'd1;
        if (hold_cnt >= hold_ticks) begin
          hold_cnt = '0;
          if (phase == 3'd7) begin
            phase = '0;
            if (cycles_left != 0) cycles_left = cycles_left - 10'd1;
            if (cycles_left == 0) moving = 1'b0;
          end else begin
            phase = phase + 3'd1;
          end
        end
      end
    end else if (!moving) begin
      if (line_len < LINE_BYTES + 1) line_len++;
      if (rx == stepdrv_pkg::CH_HASH) begin
        if (line_len > LINE_BYTES) begin
          d.status = stepdrv_pkg::ST_OVERFLOW;
        end else if (pend_valid && pend_sign != stepdrv_pkg::SIGN_NONE) begin
          n = 100 * pend_digits[11:8] + 10 * pend_digits[7:4] + pend_digits[3:0];
          dir_ccw     = (pend_sign == stepdrv_pkg::SIGN_CCW);
          cycles_left = 10'(n + 1);
          phase       = '0;
          hold_cnt    = '0;
          moving      = 1'b1;
          d.status    = stepdrv_pkg::ST_START;
        end else begin
          d.status = stepdrv_pkg::ST_NO_X;
        end
        clear_line();
      end else if (rx == stepdrv_pkg::CH_SPACE) begin
        tok_pos = 0;
        tok_x   = 1'b0;
      end else begin
        if (tok_pos == 0) begin
          tok_x = (rx == stepdrv_pkg::CH_X);
          if (tok_x) begin
            pend_sign   = stepdrv_pkg::SIGN_NONE;
            pend_digits = '0;
            pend_valid  = 1'b0;
          end
        end else if (tok_x && tok_pos == 1) begin
          pend_sign = (rx == stepdrv_pkg::CH_0)     ? stepdrv_pkg::SIGN_CW :
                      (rx == stepdrv_pkg::CH_MINUS) ? stepdrv_pkg::SIGN_CCW :
                                                      stepdrv_pkg::SIGN_NONE;
        end else if (tok_x && tok_pos <= 4) begin
          if (rx >= stepdrv_pkg::CH_0 && rx <= stepdrv_pkg::CH_9 &&
              pend_sign != stepdrv_pkg::SIGN_NONE) begin
            pend_digits = {pend_digits[7:0], 4'(rx - stepdrv_pkg::CH_0)};
            if (tok_pos == 4) pend_valid = 1'b1;
          end else begin
            pend_sign = stepdrv_pkg::SIGN_NONE;
          end
        end
        if (tok_pos < 5) tok_pos++;
      end
    end
    d.busy  = moving;
    d.coils = !moving ? 4'd0 : dir_ccw ? CCW_COILS[4*phase +: 4] : CW_COILS[4*phase +: 4];
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hold_ticks  = stepdrv_pkg::HOLD_RESET;
      clear_line();
      dir_ccw     = 1'b0;
      cycles_left = '0;
      phase       = '0;
      hold_cnt    = '0;
      moving      = 1'b0;
      drive_due.delete();
    end else begin
      if (cfg_we) hold_ticks = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        got.coils  = m_axis_tdata[3:0];
        got.busy   = m_axis_tdata[4];
        got.status = m_axis_tdata[6:5];
        if (drive_due.size() == 0) begin
          $error("result beat with no expectation waiting: tdata %0h", m_axis_tdata);
          errs++;
        end else begin
          due = drive_due.pop_front();
          n_beats++;
          if (due.status == stepdrv_pkg::ST_START) n_start++;
          if (due.status == stepdrv_pkg::ST_NO_X) n_rej++;
          if (due.status == stepdrv_pkg::ST_OVERFLOW) n_ovf++;
          if (got.coils !== due.coils) begin
            $error("coils: expected %0d, got %0d", due.coils, got.coils);
            errs++;
          end
          if (got.busy !== due.busy) begin
            $error("busy_res: expected %0d, got %0d", due.busy, got.busy);
            errs++;
          end
          if (got.status !== due.status) begin
            $error("line_status: expected %0d, got %0d", due.status, got.status);
            errs++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_drive(s_axis_tuser, s_axis_tdata, fresh);
        drive_due.push_back(fresh);
      end
    end
    fails         <= errs;
    waiting       <= drive_due.size();
    motor_busy    <= moving;
    beats_checked <= n_beats;
    starts        <= n_start;
    rejects       <= n_rej;
    overflows     <= n_ovf;
  end

endmodule

### verif/stepper_command_half_step_driver_tb.sv
// ----------------------------------------------------------------------------
// stepper_command_half_step_driver_tb
// Drives command lines and ticks into the half-step driver with random
// gaps and back-pressure, sweeps the hold setting, and leaves prediction
// and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module stepper_command_half_step_driver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_BYTES = 32;
  localparam int SEND_LIMIT = 750;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       s_axis_tuser = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  int   fails, waiting, beats_checked, starts, rejects, overflows;
  logic motor_busy;
  int   items_sent = 0;
  bit   steady = 1'b0;
  int   stall_req = 0;

  stepper_command_half_step_driver #(.LINE_BYTES(LINE_BYTES)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  stepper_command_half_step_driver_chk #(.LINE_BYTES(LINE_BYTES)) i_chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fails         (fails),
    .waiting       (waiting),
    .motor_busy    (motor_busy),
    .beats_checked (beats_checked),
    .starts        (starts),
    .rejects       (rejects),
    .overflows     (overflows)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (stall_req != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall_req) @(posedge clk);
        stall_req = 0;
      end
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  task automatic send_beat(input logic act, input logic [7:0] rx);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= rx;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_beat(1'b0, txt[i]);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_beat(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_hold(input logic [7:0] ticks);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic finish_motion();
    drain();
    while (motor_busy) begin
      send_ticks(16);
      drain();
    end
  endtask

  function automatic logic [7:0] token_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == stepdrv_pkg::CH_SPACE || c == stepdrv_pkg::CH_HASH);
    return c;
  endfunction

  task automatic random_line();
    logic [7:0] line[$];
    int kind, tens, units, xi, target;
    kind = $urandom_range(0, 99);
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 4)) line.push_back(token_byte());
      line.push_back(stepdrv_pkg::CH_SPACE);
    end
    if (kind < 85) begin
      tens  = ($urandom_range(0, 15) == 0) ? 1 : 0;
      units = ($urandom_range(0, 9) == 0) ? 9 : $urandom_range(0, 2);
      xi = line.size();
      line.push_back(stepdrv_pkg::CH_X);
      line.push_back($urandom_range(0, 1) ? stepdrv_pkg::CH_MINUS : stepdrv_pkg::CH_0);
      line.push_back(stepdrv_pkg::CH_0);
      line.push_back(stepdrv_pkg::CH_0 + 8'(tens));
      line.push_back(stepdrv_pkg::CH_0 + 8'(units));
      if (kind >= 65) line[xi + $urandom_range(1, 4)] = token_byte();
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) line.push_back(token_byte());
      if ($urandom_range(0, 3) == 0) begin
        line.push_back(stepdrv_pkg::CH_SPACE);
        repeat ($urandom_range(1, 3)) line.push_back(token_byte());
      end
    end else if (kind < 93) begin
      repeat ($urandom_range(0, 10))
        line.push_back(($urandom_range(0, 3) == 0) ? stepdrv_pkg::CH_SPACE : token_byte());
    end else begin
      // lengths around the buffer size, both sides of the limit
      target = $urandom_range(LINE_BYTES - 3, LINE_BYTES + 8);
      line.push_back(stepdrv_pkg::CH_X);
      line.push_back(stepdrv_pkg::CH_0);
      line.push_back(stepdrv_pkg::CH_0);
      line.push_back(stepdrv_pkg::CH_0);
      line.push_back(stepdrv_pkg::CH_0 + 8'($urandom_range(0, 1)));
      line.push_back(stepdrv_pkg::CH_SPACE);
      while (line.size() < target - 1) line.push_back(token_byte());
    end
    line.push_back(stepdrv_pkg::CH_HASH);
    foreach (line[i]) send_beat(1'b0, line[i]);
    if ($urandom_range(0, 3) == 0) begin
      send_ticks($urandom_range(0, 3));
      repeat ($urandom_range(1, 4))
        send_beat(1'b0, ($urandom_range(0, 2) == 0) ? stepdrv_pkg::CH_HASH :
                                                      8'($urandom_range(0, 255)));
    end
    finish_motion();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_ticks(1);
    send_text("#");
    send_text("X+001#");
    send_text("X-9a1#");
    send_text("X0000#");
    finish_motion();
    write_hold(8'd0);
    send_text("X0002 X-0017#");
    send_ticks(3);
    send_text("X00#");
    finish_motion();
    send_text("X0005 X+#");
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'hFF);
    send_text(" X-010#");
    finish_motion();
    write_hold(8'd255);
    send_text("X0000 ");
    repeat (LINE_BYTES - 7) send_beat(1'b0, "b");
    send_text("#");
    send_ticks(3);
    write_hold(8'd2);
    finish_motion();
    send_text("X0000 ");
    repeat (LINE_BYTES - 6) send_beat(1'b0, "b");
    send_text("#");

    // receiver holds off while the sender keeps offering beats
    steady = 1'b1;
    stall_req = 80;
    send_text("X0002#");
    send_ticks(24);
    steady = 1'b0;
    finish_motion();

    while (items_sent < SEND_LIMIT) begin
      if ($urandom_range(0, 7) == 0) write_hold(8'($urandom_range(0, 3)));
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) send_ticks($urandom_range(1, 3));
      random_line();
    end
    steady = 1'b0;

    // longest count: started and run for a few phases only
    write_hold(8'd1);
    send_text("X-999#");
    send_ticks(24);

    drain();
    repeat (8) @(posedge clk);
    $display("summary: %0d result beats checked, %0d motions started, %0d lines without a valid X,",
             beats_checked, starts, rejects);
    $display("summary: %0d overflowed lines, hold settings 0 to 4 and 255, 1000-cycle motion started",
             overflows);
    if (fails == 0 && waiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
